// ===== src/dopq_pkg.sv =====
// ----------------------------------------------------------------------------
// dopq_pkg
// Shared types and constants for the distance ordered priority queue.
// ----------------------------------------------------------------------------
package dopq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int AW          = $clog2(QUEUE_DEPTH);
	localparam int CW          = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W       = $clog2(2 * QUEUE_DEPTH);
	localparam int KEY_W       = 32;
	localparam int REF_W       = 20;
	localparam int FUNC_W      = 2;
	localparam int STAT_W      = 2;
	localparam int OCC_W       = 7;

	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_PURGE = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_PUSH_CHK,
		S_PUSH_CMP,
		S_PURGE_CHK,
		S_PURGE_CMP,
		S_POP_TAKE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [REF_W-1:0] nref;
	} entry_t;

	typedef struct packed {
		logic load;
		logic rd_head;
		logic rd_tail;
		logic shift;
		logic place;
		logic dec_idx;
		logic trim;
		logic take;
		logic flag_full;
		logic flag_empty;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              full;
		logic              count_zero;
		logic              idx_zero;
		logic              above;
		logic              out_free;
	} stat_t;

	function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(QUEUE_DEPTH)) begin
			sum = sum - SUM_W'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

endpackage

// ===== src/dopq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dopq_ctrl
// Operation sequencer: decodes the item, walks the tail for push and purge,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module dopq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  dopq_pkg::stat_t  st,
	output dopq_pkg::cmd_t   cmd
);

	dopq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dopq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dopq_pkg::S_IDLE: begin
				if (in_valid) state_d = dopq_pkg::S_DECODE;
			end
			dopq_pkg::S_DECODE: begin
				case (st.func)
					dopq_pkg::OP_PUSH:
						state_d = st.full ? dopq_pkg::S_FINISH : dopq_pkg::S_PUSH_CHK;
					dopq_pkg::OP_POP:
						state_d = st.count_zero ? dopq_pkg::S_FINISH : dopq_pkg::S_POP_TAKE;
					dopq_pkg::OP_PURGE:
						state_d = dopq_pkg::S_PURGE_CHK;
					default:
						state_d = dopq_pkg::S_FINISH;
				endcase
			end
			dopq_pkg::S_PUSH_CHK: begin
				state_d = st.idx_zero ? dopq_pkg::S_FINISH : dopq_pkg::S_PUSH_CMP;
			end
			dopq_pkg::S_PUSH_CMP: begin
				state_d = st.above ? dopq_pkg::S_PUSH_CHK : dopq_pkg::S_FINISH;
			end
			dopq_pkg::S_PURGE_CHK: begin
				state_d = st.idx_zero ? dopq_pkg::S_FINISH : dopq_pkg::S_PURGE_CMP;
			end
			dopq_pkg::S_PURGE_CMP: begin
				state_d = st.above ? dopq_pkg::S_PURGE_CHK : dopq_pkg::S_FINISH;
			end
			dopq_pkg::S_POP_TAKE: begin
				state_d = dopq_pkg::S_FINISH;
			end
			dopq_pkg::S_FINISH: begin
				if (st.out_free) state_d = dopq_pkg::S_IDLE;
			end
			default: state_d = dopq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			dopq_pkg::S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			dopq_pkg::S_DECODE: begin
				case (st.func)
					dopq_pkg::OP_PUSH: cmd.flag_full = st.full;
					dopq_pkg::OP_POP: begin
						cmd.flag_empty = st.count_zero;
						cmd.rd_head    = !st.count_zero;
					end
					default: cmd = '0;
				endcase
			end
			dopq_pkg::S_PUSH_CHK: begin
				cmd.place   = st.idx_zero;
				cmd.rd_tail = !st.idx_zero;
			end
			dopq_pkg::S_PUSH_CMP: begin
				cmd.shift = st.above;
				cmd.place = !st.above;
			end
			dopq_pkg::S_PURGE_CHK: begin
				cmd.trim    = st.idx_zero;
				cmd.rd_tail = !st.idx_zero;
			end
			dopq_pkg::S_PURGE_CMP: begin
				cmd.dec_idx = st.above;
				cmd.trim    = !st.above;
			end
			dopq_pkg::S_POP_TAKE: begin
				cmd.take = 1'b1;
			end
			dopq_pkg::S_FINISH: begin
				cmd.finish = st.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== src/dopq_datapath.sv =====
// ----------------------------------------------------------------------------
// dopq_datapath
// Circular entry memory with head pointer and count, tail walk index,
// result registers and the output register.
// ----------------------------------------------------------------------------
module dopq_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dopq_pkg::cmd_t                cmd,
	output dopq_pkg::stat_t               st,
	input  logic [dopq_pkg::FUNC_W-1:0]   func,
	input  logic [dopq_pkg::KEY_W-1:0]    distance,
	input  logic [dopq_pkg::REF_W-1:0]    node_ref,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dopq_pkg::REF_W-1:0]    popped_ref,
	output logic [dopq_pkg::KEY_W-1:0]    popped_distance,
	output logic [dopq_pkg::STAT_W-1:0]   status,
	output logic [dopq_pkg::OCC_W-1:0]    occupancy
);

	dopq_pkg::entry_t mem [dopq_pkg::QUEUE_DEPTH];
	dopq_pkg::entry_t rd_q;

	logic [dopq_pkg::AW-1:0]     head_q;
	logic [dopq_pkg::CW-1:0]     count_q;
	logic [dopq_pkg::CW-1:0]     idx_q;
	logic [dopq_pkg::FUNC_W-1:0] func_q;
	logic [dopq_pkg::KEY_W-1:0]  key_q;
	logic [dopq_pkg::REF_W-1:0]  ref_q;
	logic [dopq_pkg::REF_W-1:0]  res_ref_q;
	logic [dopq_pkg::KEY_W-1:0]  res_dist_q;
	logic [dopq_pkg::STAT_W-1:0] res_status_q;
	logic                        out_valid_q;
	logic [dopq_pkg::REF_W-1:0]  out_ref_q;
	logic [dopq_pkg::KEY_W-1:0]  out_dist_q;
	logic [dopq_pkg::STAT_W-1:0] out_status_q;
	logic [dopq_pkg::OCC_W-1:0]  out_occ_q;

	logic [dopq_pkg::AW-1:0] rd_addr;
	logic [dopq_pkg::AW-1:0] wr_addr;
	logic [dopq_pkg::AW-1:0] head_next;

	assign wr_addr   = dopq_pkg::wrap_addr(head_q, idx_q);
	assign rd_addr   = cmd.rd_head ? head_q
		: dopq_pkg::wrap_addr(head_q, idx_q - dopq_pkg::CW'(1));
	assign head_next = (head_q == dopq_pkg::AW'(dopq_pkg::QUEUE_DEPTH - 1))
		? '0 : head_q + dopq_pkg::AW'(1);

	always_ff @(posedge clk) begin
		if (cmd.rd_head || cmd.rd_tail) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.shift) begin
			mem[wr_addr] <= rd_q;
		end else if (cmd.place) begin
			mem[wr_addr] <= '{key: key_q, nref: ref_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.place) begin
				count_q <= count_q + dopq_pkg::CW'(1);
			end else if (cmd.trim) begin
				count_q <= idx_q;
			end else if (cmd.take) begin
				count_q <= count_q - dopq_pkg::CW'(1);
				head_q  <= head_next;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q       <= func;
			key_q        <= distance;
			ref_q        <= node_ref;
			idx_q        <= count_q;
			res_ref_q    <= '0;
			res_dist_q   <= '0;
			res_status_q <= dopq_pkg::ST_DONE;
		end else begin
			if (cmd.shift || cmd.dec_idx) begin
				idx_q <= idx_q - dopq_pkg::CW'(1);
			end
			if (cmd.flag_full) begin
				res_status_q <= dopq_pkg::ST_FULL;
			end
			if (cmd.flag_empty) begin
				res_status_q <= dopq_pkg::ST_EMPTY;
			end
			if (cmd.take) begin
				res_ref_q  <= rd_q.nref;
				res_dist_q <= rd_q.key;
			end
		end
		if (cmd.finish) begin
			out_ref_q    <= res_ref_q;
			out_dist_q   <= res_dist_q;
			out_status_q <= res_status_q;
			out_occ_q    <= dopq_pkg::OCC_W'(count_q);
		end
	end

	assign st.func       = func_q;
	assign st.full       = (count_q == dopq_pkg::CW'(dopq_pkg::QUEUE_DEPTH));
	assign st.count_zero = (count_q == '0);
	assign st.idx_zero   = (idx_q == '0);
	assign st.above      = (rd_q.key > key_q);
	assign st.out_free   = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign popped_ref      = out_ref_q;
	assign popped_distance = out_dist_q;
	assign status          = out_status_q;
	assign occupancy       = out_occ_q;

endmodule

// ===== src/distance_ordered_priority_queue.sv =====
// ----------------------------------------------------------------------------
// distance_ordered_priority_queue
// Sorted (distance, node ref) queue with push, pop and purge above threshold.
// A push or purge compares entries one by one from the tail; pops, unused op
// codes and flagged push/pop skip the walk. The next item is accepted in the
// cycle after the result is loaded; a stalled result holds the next item back.
// Reset empties the queue at once.
// ----------------------------------------------------------------------------
module distance_ordered_priority_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dopq_pkg::FUNC_W-1:0]   func,
	input  logic [dopq_pkg::KEY_W-1:0]    distance,
	input  logic [dopq_pkg::REF_W-1:0]    node_ref,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dopq_pkg::REF_W-1:0]    popped_ref,
	output logic [dopq_pkg::KEY_W-1:0]    popped_distance,
	output logic [dopq_pkg::STAT_W-1:0]   status,
	output logic [dopq_pkg::OCC_W-1:0]    occupancy
);

	dopq_pkg::cmd_t  cmd;
	dopq_pkg::stat_t st;

	dopq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	dopq_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.func            (func),
		.distance        (distance),
		.node_ref        (node_ref),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.popped_ref      (popped_ref),
		.popped_distance (popped_distance),
		.status          (status),
		.occupancy       (occupancy)
	);

endmodule

// ===== src/dopq_checker.sv =====
// ----------------------------------------------------------------------------
// dopq_checker
// Port-level checks for the distance ordered priority queue.
// ----------------------------------------------------------------------------
module dopq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [dopq_pkg::REF_W-1:0]    popped_ref,
	input logic [dopq_pkg::KEY_W-1:0]    popped_distance,
	input logic [dopq_pkg::STAT_W-1:0]   status,
	input logic [dopq_pkg::OCC_W-1:0]    occupancy
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(popped_ref)
		&& $stable(popped_distance) && $stable(status) && $stable(occupancy))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("new item taken while one is in flight");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dopq_pkg::ST_FULL |->
		occupancy == dopq_pkg::OCC_W'(dopq_pkg::QUEUE_DEPTH)
		&& popped_ref == '0 && popped_distance == '0)
		else $error("dropped push with queue not full");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dopq_pkg::ST_EMPTY |->
		occupancy == '0 && popped_ref == '0 && popped_distance == '0)
		else $error("empty pop with entries or payload");

endmodule

bind distance_ordered_priority_queue dopq_checker u_dopq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.popped_ref      (popped_ref),
	.popped_distance (popped_distance),
	.status          (status),
	.occupancy       (occupancy)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the distance ordered priority queue item by item against a sorted
// list kept in the bench: directed corner cases, a fill to overflow, random
// push/pop/purge traffic with unused op codes, and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [dopq_pkg::FUNC_W-1:0] OP_NONE = 2'd3;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES = 300;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		logic [dopq_pkg::REF_W-1:0]  nref;
		logic [dopq_pkg::KEY_W-1:0]  key;
		dopq_pkg::status_t           status;
		logic [dopq_pkg::OCC_W-1:0]  occupancy;
	} queue_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [dopq_pkg::FUNC_W-1:0]    func = '0;
	logic [dopq_pkg::KEY_W-1:0]     distance = '0;
	logic [dopq_pkg::REF_W-1:0]     node_ref = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [dopq_pkg::REF_W-1:0]     popped_ref;
	logic [dopq_pkg::KEY_W-1:0]     popped_distance;
	logic [dopq_pkg::STAT_W-1:0]    status;
	logic [dopq_pkg::OCC_W-1:0]     occupancy;

	dopq_pkg::entry_t sorted_entries[$];
	queue_result_t    pending_results[$];

	int err_count = 0;
	int checked_count = 0;
	int burst_left = 0;
	int hold_request = 0;
	int cycle_count = 0;
	int n_push = 0, n_full = 0, n_pop = 0, n_empty = 0, n_purge = 0, n_none = 0;

	distance_ordered_priority_queue u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.distance        (distance),
		.node_ref        (node_ref),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.popped_ref      (popped_ref),
		.popped_distance (popped_distance),
		.status          (status),
		.occupancy       (occupancy)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int first_above(input logic [dopq_pkg::KEY_W-1:0] k);
		for (int i = 0; i < sorted_entries.size(); i++) begin
			if (sorted_entries[i].key > k) begin
				return i;
			end
		end
		return sorted_entries.size();
	endfunction

	function automatic queue_result_t predict_queue_op(
		input logic [dopq_pkg::FUNC_W-1:0] f,
		input logic [dopq_pkg::KEY_W-1:0] d, input logic [dopq_pkg::REF_W-1:0] r);
		queue_result_t    res;
		dopq_pkg::entry_t e;
		int               pos;
		res.nref = '0;
		res.key = '0;
		res.status = dopq_pkg::ST_DONE;
		case (f)
		dopq_pkg::OP_PUSH: begin
			n_push++;
			if (sorted_entries.size() >= dopq_pkg::QUEUE_DEPTH) begin
				res.status = dopq_pkg::ST_FULL;
				n_full++;
			end else begin
				e.key = d;
				e.nref = r;
				sorted_entries.insert(first_above(d), e);
			end
		end
		dopq_pkg::OP_POP: begin
			n_pop++;
			if (sorted_entries.size() == 0) begin
				res.status = dopq_pkg::ST_EMPTY;
				n_empty++;
			end else begin
				e = sorted_entries.pop_front();
				res.key = e.key;
				res.nref = e.nref;
			end
		end
		dopq_pkg::OP_PURGE: begin
			n_purge++;
			pos = first_above(d);
			while (sorted_entries.size() > pos) begin
				void'(sorted_entries.pop_back());
			end
		end
		default: begin
			n_none++;
		end
		endcase
		res.occupancy = dopq_pkg::OCC_W'(sorted_entries.size());
		return res;
	endfunction

	task automatic send_item(input logic [dopq_pkg::FUNC_W-1:0] f,
		input logic [dopq_pkg::KEY_W-1:0] d, input logic [dopq_pkg::REF_W-1:0] r);
		int            gap;
		queue_result_t predicted;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= f;
		distance <= d;
		node_ref <= r;
		do begin
			@(posedge clk);
		end while (in_stall);
		predicted = predict_queue_op(f, d, r);
		pending_results.insert(pending_results.size(), predicted);
	endtask

	function automatic logic [dopq_pkg::KEY_W-1:0] pick_key();
		case ($urandom_range(0, 5))
		0: return $urandom_range(0, 7);
		1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
		2: return 32'h0001_0000 + $urandom_range(0, 3);
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [dopq_pkg::KEY_W-1:0] pick_threshold();
		logic [dopq_pkg::KEY_W-1:0] k;
		if (sorted_entries.size() != 0 && $urandom_range(0, 9) < 7) begin
			k = sorted_entries[$urandom_range(0, sorted_entries.size() - 1)].key;
			case ($urandom_range(0, 2))
			0: return k - 1;
			1: return k;
			default: return k + 1;
			endcase
		end
		return pick_key();
	endfunction

	task automatic test_directed_corners();
		send_item(dopq_pkg::OP_POP, '1, '1);
		send_item(OP_NONE, '0, '0);
		send_item(dopq_pkg::OP_PURGE, '0, '0);
		send_item(dopq_pkg::OP_PUSH, 32'hFFFF_FFFF, 20'hF_FFFF);
		send_item(dopq_pkg::OP_PUSH, 32'h0000_0000, 20'h0_0000);
		send_item(dopq_pkg::OP_PUSH, 32'h0001_0000, 20'h0_0001);
		send_item(dopq_pkg::OP_PUSH, 32'h0001_0000, 20'h0_0002);
		send_item(dopq_pkg::OP_PUSH, 32'h0001_0000, 20'h0_0003);
		send_item(dopq_pkg::OP_PUSH, 32'h0000_8000, 20'h5_A5A5);
		send_item(dopq_pkg::OP_PURGE, 32'hFFFF_FFFF, 20'hA_5A5A);
		send_item(OP_NONE, 32'hDEAD_BEEF, 20'hF_FFFF);
		send_item(dopq_pkg::OP_PURGE, 32'h0001_0000, '0);
		repeat (5) send_item(dopq_pkg::OP_POP, '0, '0);
		send_item(dopq_pkg::OP_POP, '0, '0);
		send_item(dopq_pkg::OP_PUSH, 32'hFFFF_FFFF, 20'h0_0001);
		send_item(dopq_pkg::OP_PUSH, 32'hFFFF_FFFF, 20'h0_0002);
		send_item(dopq_pkg::OP_PURGE, '0, '0);
		send_item(dopq_pkg::OP_PUSH, '0, 20'hA_AAAA);
		send_item(dopq_pkg::OP_PURGE, '0, '0);
		send_item(dopq_pkg::OP_POP, '0, '0);
	endtask

	task automatic test_fill_overflow();
		while (sorted_entries.size() < dopq_pkg::QUEUE_DEPTH) begin
			send_item(dopq_pkg::OP_PUSH, pick_key(), dopq_pkg::REF_W'($urandom));
		end
		repeat (3) send_item(dopq_pkg::OP_PUSH, pick_key(), dopq_pkg::REF_W'($urandom));
		send_item(dopq_pkg::OP_POP, '0, '0);
		repeat (2) send_item(dopq_pkg::OP_PUSH, pick_key(), dopq_pkg::REF_W'($urandom));
		send_item(dopq_pkg::OP_PURGE, '1, '0);
		send_item(dopq_pkg::OP_PURGE, pick_threshold(), '0);
		while (sorted_entries.size() != 0) begin
			send_item(dopq_pkg::OP_POP, '0, '0);
		end
		send_item(dopq_pkg::OP_POP, '0, '0);
	endtask

	task automatic test_random_traffic(input int n_items);
		int phase_left;
		int push_pct;
		int roll;
		phase_left = 0;
		push_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(40, 160);
				case ($urandom_range(0, 2))
				0: push_pct = 80;
				1: push_pct = 25;
				default: push_pct = 50;
				endcase
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			if (roll < 2) begin
				send_item(OP_NONE, $urandom, dopq_pkg::REF_W'($urandom));
			end else if (roll < 9) begin
				send_item(dopq_pkg::OP_PURGE, pick_threshold(), dopq_pkg::REF_W'($urandom));
			end else if ($urandom_range(0, 99) < push_pct) begin
				send_item(dopq_pkg::OP_PUSH, pick_key(), dopq_pkg::REF_W'($urandom));
			end else begin
				send_item(dopq_pkg::OP_POP, $urandom, dopq_pkg::REF_W'($urandom));
			end
		end
	endtask

	task automatic test_output_holdoff();
		hold_request = 400;
		burst_left = 60;
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(0, 2) != 0) begin
				send_item(dopq_pkg::OP_PUSH, pick_key(), dopq_pkg::REF_W'($urandom));
			end else begin
				send_item(dopq_pkg::OP_POP, '0, '0);
			end
		end
	endtask

	initial begin : stall_driver
		int mode;
		int mode_left;
		int hold_left;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_checker
		queue_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= REPORT_MAX) begin
					$display("%0t: unexpected result ref=%h dist=%h status=%0d occ=%0d",
						$realtime, popped_ref, popped_distance, status, occupancy);
				end
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (popped_ref !== want.nref || popped_distance !== want.key ||
					status !== want.status || occupancy !== want.occupancy) begin
					err_count++;
					if (err_count <= REPORT_MAX) begin
						$display("%0t: mismatch exp ref=%h dist=%h status=%0d occ=%0d",
							$realtime, want.nref, want.key, want.status, want.occupancy);
						$display("%0t:          got ref=%h dist=%h status=%0d occ=%0d",
							$realtime, popped_ref, popped_distance, status, occupancy);
					end
				end
			end
		end
	end

	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles, %0d results pending",
					cycle_count, pending_results.size());
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin : main_sequence
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_fill_overflow();
		test_output_holdoff();
		test_random_traffic(1480);
		@(posedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d pushes (%0d dropped full), %0d pops (%0d on empty),",
			n_push, n_full, n_pop, n_empty);
		$display("%0d purges, %0d unused codes; %0d results checked, %0d errors",
			n_purge, n_none, checked_count, err_count);
		if (err_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/dopq_pkg.sv
src/dopq_ctrl.sv
src/dopq_datapath.sv
src/distance_ordered_priority_queue.sv
src/dopq_checker.sv
verif/testbench.sv
